// ===== rtl/core/tmpi_pkg.sv =====
// Shared types and constants for the traffic matrix packet injector.
// No dependencies; used by tmpi_front, tmpi_back and the top level.
package tmpi_pkg;

  localparam int unsigned NODE_BITS   = 6;
  localparam int unsigned NODES       = 1 << NODE_BITS;
  localparam int unsigned CELL_BITS   = 2 * NODE_BITS;
  localparam int unsigned CELLS       = 1 << CELL_BITS;
  localparam int unsigned COUNT_BITS  = 24;
  localparam int unsigned TOTAL_BITS  = 36;
  localparam int unsigned PNUM_BITS   = 32;
  localparam int unsigned MAX_FLITS   = 16;
  localparam int unsigned FIDX_BITS   = 4;
  localparam int unsigned CFG_BITS    = 5;
  localparam int unsigned ACTION_BITS = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_INJECT  = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_PTR,
    ST_SEARCH,
    ST_TAKE,
    ST_EMIT,
    ST_ACK,
    ST_RESTART
  } state_e;

  // One classified request as it waits in the queue.
  typedef struct packed {
    op_e                   op;
    logic [NODE_BITS-1:0]  src;
    logic [NODE_BITS-1:0]  dst;
    logic [COUNT_BITS-1:0] cnt;
  } req_t;

  // Queue status towards the back end.
  typedef struct packed {
    logic valid;
    req_t req;
  } queue_out_t;

endpackage

// ===== rtl/core/traffic_matrix_packet_injector.sv =====
// Flow: a load answers once popped; a restart answers after copying every cell;
// an inject reads its pointer, searches up to 64 destinations, then emits flits.
// The back end takes one request at a time and pops the next only when idle.
// Reset: asynchronous, active low; afterwards a clearing pass over every cell of
// both tables runs while no request is accepted (configuration still is).
module traffic_matrix_packet_injector (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tmpi_pkg::CFG_BITS-1:0]     cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // source_node[5:0], dest_node[11:6], packet_count[35:12], zero fill
  input  logic [tmpi_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // action[1:0]
  input  logic [tmpi_pkg::ACTION_BITS-1:0]  s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // flit_source[5:0], flit_dest[11:6], flit_index[15:12],
  // packet_number[47:16], batch_left[83:48], zero fill
  output logic [tmpi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // flit_valid[0], is_head[1]
  output logic [tmpi_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  output logic                              m_axis_tlast
);

  tmpi_pkg::queue_out_t queue;
  logic                 pop, clearing;

  assign cfg_ready_o = 1'b1;

  tmpi_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clearing_i    (clearing),
    .pop_i         (pop),
    .queue_o       (queue)
  );

  tmpi_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .queue_i       (queue),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/core/tmpi_front.sv =====
// Front end: accepts requests, decodes the action and queues all but unused ones.
// Depends on tmpi_pkg.
module tmpi_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // source_node[5:0], dest_node[11:6], packet_count[35:12], zero fill
  input  logic [tmpi_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // action[1:0]
  input  logic [tmpi_pkg::ACTION_BITS-1:0] s_axis_tuser,
  input  logic                           clearing_i,
  input  logic                           pop_i,
  output tmpi_pkg::queue_out_t           queue_o
);

  tmpi_pkg::req_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     fill_q, fill_d;
  logic           push, keep, take;
  tmpi_pkg::req_t dec;

  always_comb begin
    dec.src = s_axis_tdata[tmpi_pkg::NODE_BITS-1:0];
    dec.dst = s_axis_tdata[2*tmpi_pkg::NODE_BITS-1:tmpi_pkg::NODE_BITS];
    dec.cnt = s_axis_tdata[2*tmpi_pkg::NODE_BITS+tmpi_pkg::COUNT_BITS-1:
                           2*tmpi_pkg::NODE_BITS];
    dec.op  = tmpi_pkg::OP_LOAD;
    keep    = 1'b1;
    unique case (s_axis_tuser)
      tmpi_pkg::OP_LOAD:    dec.op = tmpi_pkg::OP_LOAD;
      tmpi_pkg::OP_INJECT:  dec.op = tmpi_pkg::OP_INJECT;
      tmpi_pkg::OP_RESTART: dec.op = tmpi_pkg::OP_RESTART;
      default: keep = 1'b0;  // unused action is swallowed without a result
    endcase
  end

  assign s_axis_tready = (fill_q != 2'd2) && !clearing_i;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign push          = take && keep;

  always_comb begin
    fill_d = fill_q;
    if (push && !pop_i) fill_d = fill_q + 2'd1;
    else if (!push && pop_i) fill_d = fill_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= dec;
  end

  assign queue_o.valid = (fill_q != 2'd0);
  assign queue_o.req   = entry_q[rd_ptr_q];

endmodule

// ===== rtl/core/tmpi_back.sv =====
// Back end: table memories, round-robin search, batch restart and flit output.
// Depends on tmpi_pkg; fed from tmpi_front through its queue.
module tmpi_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tmpi_pkg::CFG_BITS-1:0]     cfg_data_i,
  input  tmpi_pkg::queue_out_t              queue_i,
  output logic                              pop_o,
  output logic                              clearing_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tmpi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic [tmpi_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  output logic                              m_axis_tlast
);

  localparam int unsigned NB = tmpi_pkg::NODE_BITS;
  localparam int unsigned CB = tmpi_pkg::CELL_BITS;
  localparam int unsigned KB = tmpi_pkg::COUNT_BITS;
  localparam int unsigned TB = tmpi_pkg::TOTAL_BITS;
  localparam int unsigned PB = tmpi_pkg::PNUM_BITS;
  localparam int unsigned FB = tmpi_pkg::FIDX_BITS;
  localparam int unsigned OB = tmpi_pkg::OUT_TDATA_W;
  localparam logic [tmpi_pkg::CFG_BITS-1:0] CFG_BITS_MAX =
    tmpi_pkg::CFG_BITS'(tmpi_pkg::MAX_FLITS);

  tmpi_pkg::state_e state_q, state_d;

  // Memories
  logic [KB-1:0] cnt_mem [tmpi_pkg::CELLS];
  logic [KB-1:0] rem_mem [tmpi_pkg::CELLS];
  logic [NB-1:0] rr_mem  [tmpi_pkg::NODES];
  logic [tmpi_pkg::NODES-1:0] rr_valid_q;

  logic          cnt_we, cnt_re, rem_we, rem_re, rr_we, rr_re, rr_clear;
  logic [CB-1:0] cnt_waddr, cnt_raddr, rem_waddr, rem_raddr;
  logic [KB-1:0] cnt_wdata, rem_wdata, cnt_rdata_q, rem_rdata_q;
  logic [NB-1:0] rr_addr, rr_wdata, rr_rdata_q;
  logic          rr_hit_q;

  // Control and datapath registers
  logic [CB:0]     idx_q, idx_d;
  logic            chk_vld_q, chk_vld_d;
  logic [CB-1:0]   chk_addr_q, chk_addr_d;
  logic [NB-1:0]   ptr_q, ptr_d, dest_q, dest_d, chk_dest_q, chk_dest_d;
  logic [NB:0]     issue_q, issue_d;
  logic [NB-1:0]   ack_src_q, ack_src_d;
  tmpi_pkg::req_t  req_q, req_d;
  logic [PB-1:0]   pcnt_q, pcnt_d, pid_q, pid_d;
  logic [TB-1:0]   total_q, total_d;
  logic [FB-1:0]   fidx_q, fidx_d, last_idx_q;
  logic            out_vld_q, out_vld_d, out_load, out_free;
  logic [tmpi_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [tmpi_pkg::OUT_TUSER_W-1:0] out_user_q, out_user_d;
  logic            out_last_q, out_last_d;
  logic            hit;

  assign out_free = !out_vld_q || m_axis_tready;
  assign hit      = chk_vld_q && (rem_rdata_q != '0);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    chk_vld_d  = 1'b0;
    chk_addr_d = chk_addr_q;
    chk_dest_d = chk_dest_q;
    ptr_d      = ptr_q;
    dest_d     = dest_q;
    issue_d    = issue_q;
    ack_src_d  = ack_src_q;
    req_d      = req_q;
    pcnt_d     = pcnt_q;
    pid_d      = pid_q;
    total_d    = total_q;
    fidx_d     = fidx_q;
    pop_o      = 1'b0;
    cnt_we = 1'b0; cnt_re = 1'b0; rem_we = 1'b0; rem_re = 1'b0;
    rr_we  = 1'b0; rr_re  = 1'b0; rr_clear = 1'b0;
    cnt_waddr = {req_q.src, req_q.dst};
    cnt_wdata = req_q.cnt;
    cnt_raddr = idx_q[CB-1:0];
    rem_waddr = chk_addr_q;
    rem_wdata = cnt_rdata_q;
    rem_raddr = {req_q.src, ptr_q + issue_q[NB-1:0]};
    rr_addr   = req_q.src;
    rr_wdata  = dest_q + NB'(1);
    out_load  = 1'b0;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    out_last_d = out_last_q;

    unique case (state_q)
      tmpi_pkg::ST_CLEAR: begin
        cnt_we    = 1'b1;
        rem_we    = 1'b1;
        cnt_waddr = idx_q[CB-1:0];
        rem_waddr = idx_q[CB-1:0];
        cnt_wdata = '0;
        rem_wdata = '0;
        idx_d     = idx_q + (CB+1)'(1);
        if (idx_q[CB-1:0] == '1) state_d = tmpi_pkg::ST_IDLE;
      end
      tmpi_pkg::ST_IDLE: begin
        if (queue_i.valid) begin
          pop_o = 1'b1;
          req_d = queue_i.req;
          unique case (queue_i.req.op)
            tmpi_pkg::OP_LOAD: begin
              cnt_we    = 1'b1;
              cnt_waddr = {queue_i.req.src, queue_i.req.dst};
              cnt_wdata = queue_i.req.cnt;
              ack_src_d = '0;
              state_d   = tmpi_pkg::ST_ACK;
            end
            tmpi_pkg::OP_INJECT: begin
              rr_re   = 1'b1;
              rr_addr = queue_i.req.src;
              state_d = tmpi_pkg::ST_RD_PTR;
            end
            default: begin
              idx_d   = '0;
              total_d = '0;
              state_d = tmpi_pkg::ST_RESTART;
            end
          endcase
        end
      end
      tmpi_pkg::ST_RD_PTR: begin
        ptr_d   = rr_hit_q ? rr_rdata_q : '0;
        issue_d = '0;
        state_d = tmpi_pkg::ST_SEARCH;
      end
      tmpi_pkg::ST_SEARCH: begin
        // One read issued per cycle; the previous read is checked alongside.
        if (!hit && !issue_q[NB]) begin
          rem_re     = 1'b1;
          chk_vld_d  = 1'b1;
          chk_dest_d = ptr_q + issue_q[NB-1:0];
          issue_d    = issue_q + (NB+1)'(1);
        end
        if (hit) begin
          dest_d  = chk_dest_q;
          state_d = tmpi_pkg::ST_TAKE;
        end else if (issue_q[NB] && chk_vld_q) begin
          ack_src_d = req_q.src;
          state_d   = tmpi_pkg::ST_ACK;
        end
      end
      tmpi_pkg::ST_TAKE: begin
        rem_we    = 1'b1;
        rem_waddr = {req_q.src, dest_q};
        rem_wdata = rem_rdata_q - KB'(1);
        rr_we     = 1'b1;
        if (total_q != '0) total_d = total_q - TB'(1);
        pid_d   = pcnt_q;
        pcnt_d  = pcnt_q + PB'(1);
        fidx_d  = '0;
        state_d = tmpi_pkg::ST_EMIT;
      end
      tmpi_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = OB'({total_q, pid_q, fidx_q, dest_q, req_q.src});
          out_user_d = {fidx_q == '0, 1'b1};
          out_last_d = (fidx_q == last_idx_q);
          fidx_d     = fidx_q + FB'(1);
          if (fidx_q == last_idx_q) state_d = tmpi_pkg::ST_IDLE;
        end
      end
      tmpi_pkg::ST_ACK: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = OB'({total_q, pcnt_q, FB'(0), NB'(0), ack_src_q});
          out_user_d = '0;
          out_last_d = 1'b1;
          state_d    = tmpi_pkg::ST_IDLE;
        end
      end
      tmpi_pkg::ST_RESTART: begin
        // Read the count table one cell a cycle; copy and sum each cell in the next cycle.
        if (!idx_q[CB]) begin
          cnt_re     = 1'b1;
          chk_vld_d  = 1'b1;
          chk_addr_d = idx_q[CB-1:0];
          idx_d      = idx_q + (CB+1)'(1);
        end
        if (chk_vld_q) begin
          rem_we  = 1'b1;
          total_d = total_q + TB'(cnt_rdata_q);
        end
        if (idx_q[CB] && !chk_vld_q) begin
          rr_clear  = 1'b1;
          ack_src_d = '0;
          state_d   = tmpi_pkg::ST_ACK;
        end
      end
      default: state_d = tmpi_pkg::ST_IDLE;
    endcase

    out_vld_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tmpi_pkg::ST_CLEAR;
      idx_q      <= '0;
      chk_vld_q  <= 1'b0;
      issue_q    <= '0;
      pcnt_q     <= '0;
      total_q    <= '0;
      fidx_q     <= '0;
      last_idx_q <= '0;
      out_vld_q  <= 1'b0;
      rr_valid_q <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      chk_vld_q <= chk_vld_d;
      issue_q   <= issue_d;
      pcnt_q    <= pcnt_d;
      total_q   <= total_d;
      fidx_q    <= fidx_d;
      out_vld_q <= out_vld_d;
      if (rr_clear) rr_valid_q <= '0;
      else if (rr_we) rr_valid_q[req_q.src] <= 1'b1;
      if (cfg_we_i) begin
        if (cfg_data_i == '0) last_idx_q <= '0;
        else if (cfg_data_i > CFG_BITS_MAX) last_idx_q <= '1;
        else last_idx_q <= FB'(cfg_data_i - tmpi_pkg::CFG_BITS'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_addr_q <= chk_addr_d;
    chk_dest_q <= chk_dest_d;
    ptr_q      <= ptr_d;
    dest_q     <= dest_d;
    ack_src_q  <= ack_src_d;
    req_q      <= req_d;
    pid_q      <= pid_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rem_we) rem_mem[rem_waddr] <= rem_wdata;
    if (rem_re) rem_rdata_q <= rem_mem[rem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rr_we) rr_mem[rr_addr] <= rr_wdata;
    if (rr_re) begin
      rr_rdata_q <= rr_mem[rr_addr];
      rr_hit_q   <= rr_valid_q[rr_addr];
    end
  end

  assign clearing_o    = (state_q == tmpi_pkg::ST_CLEAR);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmpi_pkg::ST_CLEAR) |-> !pop_o)
    else $error("request taken during clearing pass");
  a_hit_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmpi_pkg::ST_SEARCH && hit) |=> (state_q == tmpi_pkg::ST_TAKE))
    else $error("search hit not taken");
  a_total_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmpi_pkg::ST_TAKE && total_q != '0) |=>
      (total_q == $past(total_q) - TB'(1)))
    else $error("total not decremented on packet");
  a_fidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmpi_pkg::ST_EMIT) |-> (fidx_q <= last_idx_q))
    else $error("flit index beyond packet length");
`endif

endmodule

// ===== tb/tb_traffic_matrix_packet_injector.sv =====
// Self-checking testbench for traffic_matrix_packet_injector: directed and random
// requests, checked against a predictor of the table, pointer and counter state.
// Depends on rtl/core/tmpi_pkg.sv and the top level of the block.
`timescale 1ns / 100ps

module tb_traffic_matrix_packet_injector;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned NB = tmpi_pkg::NODE_BITS;
  localparam int unsigned KB = tmpi_pkg::COUNT_BITS;
  localparam int unsigned FB = tmpi_pkg::FIDX_BITS;
  localparam int unsigned CB = tmpi_pkg::CFG_BITS;

  typedef struct packed {
    logic [1:0]                      action;
    logic [tmpi_pkg::NODE_BITS-1:0]  src;
    logic [tmpi_pkg::NODE_BITS-1:0]  dst;
    logic [tmpi_pkg::COUNT_BITS-1:0] cnt;
  } request_t;

  typedef struct packed {
    logic                            valid;
    logic [tmpi_pkg::NODE_BITS-1:0]  src;
    logic [tmpi_pkg::NODE_BITS-1:0]  dst;
    logic                            head;
    logic                            last;
    logic [tmpi_pkg::FIDX_BITS-1:0]  idx;
    logic [tmpi_pkg::PNUM_BITS-1:0]  pnum;
    logic [tmpi_pkg::TOTAL_BITS-1:0] left;
  } flit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [tmpi_pkg::CFG_BITS-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [tmpi_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [tmpi_pkg::ACTION_BITS-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [tmpi_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [tmpi_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;

  traffic_matrix_packet_injector u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #6 clk_i = ~clk_i;

  // Predicted state of the injector.
  logic [tmpi_pkg::COUNT_BITS-1:0] count_tab [tmpi_pkg::CELLS];
  logic [tmpi_pkg::COUNT_BITS-1:0] remain_tab [tmpi_pkg::CELLS];
  logic [tmpi_pkg::NODE_BITS-1:0]  rr_ptr [tmpi_pkg::NODES];
  logic [tmpi_pkg::PNUM_BITS-1:0]  pkt_ctr = '0;
  logic [tmpi_pkg::TOTAL_BITS-1:0] total_left = '0;
  logic [tmpi_pkg::CFG_BITS-1:0]   flits_cfg = 5'd1;

  request_t pending_reqs[$];
  flit_t    expected_flits[$];
  request_t cur_req;
  int errors = 0;
  int n_requests = 0;
  int n_flits = 0;
  int burst_left = 1;
  int gap_left = 0;

  initial begin
    for (int i = 0; i < tmpi_pkg::CELLS; i++) begin
      count_tab[i] = '0;
      remain_tab[i] = '0;
    end
    for (int i = 0; i < tmpi_pkg::NODES; i++) rr_ptr[i] = '0;
  end

  task automatic predict_request(input request_t r);
    flit_t f;
    logic [tmpi_pkg::TOTAL_BITS-1:0] sum;
    int nfl;
    bit found;
    logic [tmpi_pkg::NODE_BITS-1:0] d, hit;
    f = '{valid: 1'b0, src: '0, dst: '0, head: 1'b0, last: 1'b1, idx: '0,
          pnum: pkt_ctr, left: total_left};
    n_requests++;
    case (r.action)
      tmpi_pkg::OP_LOAD: begin
        count_tab[{r.src, r.dst}] = r.cnt;
        expected_flits = {expected_flits, f};
      end
      tmpi_pkg::OP_RESTART: begin
        sum = '0;
        for (int i = 0; i < tmpi_pkg::CELLS; i++) begin
          remain_tab[i] = count_tab[i];
          sum += count_tab[i];
        end
        for (int i = 0; i < tmpi_pkg::NODES; i++) rr_ptr[i] = '0;
        total_left = sum;
        f.left = sum;
        expected_flits = {expected_flits, f};
      end
      tmpi_pkg::OP_INJECT: begin
        found = 1'b0;
        hit = '0;
        for (int i = 0; i < tmpi_pkg::NODES && !found; i++) begin
          d = rr_ptr[r.src] + NB'(i);
          if (remain_tab[{r.src, d}] != '0) begin
            found = 1'b1;
            hit = d;
          end
        end
        if (!found) begin
          f.src = r.src;
          expected_flits = {expected_flits, f};
        end else begin
          rr_ptr[r.src] = hit + 1'b1;
          remain_tab[{r.src, hit}] -= 1'b1;
          if (total_left != '0) total_left -= 1'b1;
          if (flits_cfg == '0) nfl = 1;
          else if (flits_cfg > tmpi_pkg::MAX_FLITS) nfl = int'(tmpi_pkg::MAX_FLITS);
          else nfl = int'(flits_cfg);
          for (int i = 0; i < nfl; i++) begin
            f = '{valid: 1'b1, src: r.src, dst: hit, head: (i == 0),
                  last: (i == nfl - 1), idx: FB'(i), pnum: pkt_ctr,
                  left: total_left};
            expected_flits = {expected_flits, f};
          end
          pkt_ctr += 1'b1;
        end
      end
      default: ;  // unused action code: no answer
    endcase
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) predict_request(cur_req);
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        s_axis_tdata <= {4'b0, cur_req.cnt, cur_req.dst, cur_req.src};
        s_axis_tuser <= cur_req.action;
        s_axis_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: rotates through always, mostly, rarely and periodically ready.
  int rx_cycle = 0;
  always @(posedge clk_i) begin
    rx_cycle++;
    case ((rx_cycle >> 8) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ((rx_cycle % 7) < 4);
    endcase
  end

  // Monitor: compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    flit_t e, a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a = '{valid: m_axis_tuser[0], src: m_axis_tdata[5:0], dst: m_axis_tdata[11:6],
            head: m_axis_tuser[1], last: m_axis_tlast, idx: m_axis_tdata[15:12],
            pnum: m_axis_tdata[47:16], left: m_axis_tdata[83:48]};
      n_flits++;
      if (expected_flits.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual valid=%0b src=%0d dst=%0d pnum=%0d",
                 $time, a.valid, a.src, a.dst, a.pnum);
      end else begin
        e = expected_flits.pop_front();
        if (a != e) begin
          errors++;
          $display({"%0t: mismatch expected valid=%0b src=%0d dst=%0d head=%0b",
                    " last=%0b idx=%0d pnum=%0d left=%0d"},
                   $time, e.valid, e.src, e.dst, e.head, e.last, e.idx, e.pnum,
                   e.left);
          $display({"%0t:          actual valid=%0b src=%0d dst=%0d head=%0b",
                    " last=%0b idx=%0d pnum=%0d left=%0d"},
                   $time, a.valid, a.src, a.dst, a.head, a.last, a.idx, a.pnum,
                   a.left);
        end
      end
    end
  end

  task automatic queue_req(input logic [1:0] act, input int s, input int d, input int c);
    request_t r;
    r = '{action: act, src: NB'(s), dst: NB'(d), cnt: KB'(c)};
    pending_reqs = {pending_reqs, r};
  endtask

  // An unused action code gives no result, so a wait of DRAIN_CYCLES covers an inject
  // still busy.
  task automatic wait_idle();
    while (!(pending_reqs.size() == 0 && !s_axis_tvalid && expected_flits.size() == 0))
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_flits(input logic [tmpi_pkg::CFG_BITS-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    flits_cfg = v;
  endtask

  int src_hi;
  logic [tmpi_pkg::CFG_BITS-1:0] flit_settings [6] = '{5'd16, 5'd0, 5'd31, 5'd3, 5'd1, 5'd2};

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, extremes of nodes and counts, unused code.
    queue_req(tmpi_pkg::OP_INJECT, 0, 0, 0);
    queue_req(tmpi_pkg::OP_LOAD, 0, 63, 2);
    queue_req(tmpi_pkg::OP_LOAD, 0, 5, 1);
    queue_req(tmpi_pkg::OP_LOAD, 63, 0, 24'hFFFFFF);
    queue_req(tmpi_pkg::OP_LOAD, 63, 63, 0);
    queue_req(ACT_UNUSED, 63, 63, 24'hFFFFFF);
    queue_req(tmpi_pkg::OP_RESTART, 0, 0, 0);
    for (int i = 0; i < 4; i++) queue_req(tmpi_pkg::OP_INJECT, 0, 0, 0);
    queue_req(tmpi_pkg::OP_LOAD, 0, 5, 7);  // must not touch the remaining counts
    queue_req(tmpi_pkg::OP_INJECT, 0, 0, 0);
    queue_req(tmpi_pkg::OP_INJECT, 63, 42, 24'h5A5A5A);
    queue_req(tmpi_pkg::OP_INJECT, 63, 0, 0);
    queue_req(tmpi_pkg::OP_INJECT, 42, 0, 0);
    wait_idle();
    write_flits(5'd16);
    queue_req(tmpi_pkg::OP_INJECT, 63, 0, 0);
    queue_req(tmpi_pkg::OP_RESTART, 0, 0, 0);
    queue_req(tmpi_pkg::OP_INJECT, 0, 0, 0);
    queue_req(tmpi_pkg::OP_LOAD, 63, 0, 0);
    queue_req(tmpi_pkg::OP_LOAD, 0, 5, 0);
    queue_req(tmpi_pkg::OP_LOAD, 0, 63, 0);
    queue_req(tmpi_pkg::OP_RESTART, 0, 0, 0);

    // Random part: batches of loads, a restart, then mostly injects.
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_flits(ph == 5 ? CB'($urandom_range(1, tmpi_pkg::MAX_FLITS))
                          : flit_settings[ph]);
      src_hi = ($urandom_range(0, 1) == 0) ? 7 : 63;
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < 6; i++)
          queue_req(tmpi_pkg::OP_LOAD, $urandom_range(0, src_hi), $urandom_range(0, 63),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                : $urandom_range(0, 3));
        queue_req(tmpi_pkg::OP_RESTART, $urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom);
        for (int i = 0; i < 12; i++) begin
          case ($urandom_range(0, 15))
            0: queue_req(ACT_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom);
            1: queue_req(tmpi_pkg::OP_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 24'hFFFFFF));
            2: queue_req(tmpi_pkg::OP_INJECT, $urandom_range(0, 63),
                         $urandom_range(0, 63), $urandom);
            default: queue_req(tmpi_pkg::OP_INJECT, $urandom_range(0, src_hi),
                               $urandom_range(0, 63), $urandom);
          endcase
        end
      end
    end

    wait_idle();
    $display("Covered %0d requests and %0d results over six flit settings.",
             n_requests, n_flits);
    $display("Settings included 0 and 31; loads, restarts, injects and unused codes mixed.");
    if (errors == 0) begin
      $display("** traffic_matrix_packet_injector: PASSED **");
    end else begin
      $display("** traffic_matrix_packet_injector: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d results still expected.", expected_flits.size());
    $display("** traffic_matrix_packet_injector: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tmpi_pkg.sv
rtl/core/tmpi_front.sv
rtl/core/tmpi_back.sv
rtl/core/traffic_matrix_packet_injector.sv
tb/tb_traffic_matrix_packet_injector.sv
